>>> rtl/tll_pkg.sv
`timescale 1ns / 1ps

package tll_pkg;

  typedef logic [7:0] char_t;
  typedef logic [4:0] state_t;
  typedef logic [3:0] class_t;
  typedef logic [3:0] kind_t;

  // Character classes
  localparam class_t ClsLetter = 4'd0;
  localparam class_t ClsDigit  = 4'd1;
  localparam class_t ClsLBrace = 4'd2;
  localparam class_t ClsRBrace = 4'd3;
  localparam class_t ClsLParen = 4'd4;
  localparam class_t ClsStar   = 4'd5;
  localparam class_t ClsRParen = 4'd6;
  localparam class_t ClsColon  = 4'd7;
  localparam class_t ClsEqual  = 4'd8;
  localparam class_t ClsLess   = 4'd9;
  localparam class_t ClsGreat  = 4'd10;
  localparam class_t ClsSpace  = 4'd11;
  localparam class_t ClsOther  = 4'd12;
  localparam class_t ClsDollar = 4'd13;

  // Token kinds
  localparam kind_t KindIdent  = 4'd0;
  localparam kind_t KindNumber = 4'd1;
  localparam kind_t KindBrace  = 4'd2;
  localparam kind_t KindParen  = 4'd3;
  localparam kind_t KindAssign = 4'd4;
  localparam kind_t KindLe     = 4'd5;
  localparam kind_t KindNe     = 4'd6;
  localparam kind_t KindGe     = 4'd7;
  localparam kind_t KindError  = 4'd8;
  localparam kind_t KindPrefix = 4'd9;
  localparam kind_t KindStop   = 4'd10;
  localparam kind_t KindNone   = 4'd15;

  // Table states that carry a name outside the table
  localparam state_t StStart  = 5'd0;
  localparam state_t StIdent  = 5'd2;
  localparam state_t StNumber = 5'd4;
  localparam state_t StPrefix = 5'd19;
  localparam state_t StStop   = 5'd20;

  // Result queue geometry
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  // Outcome of one character, from the step logic to the queue
  typedef struct packed {
    logic [1:0] cnt;
    kind_t      kind0;
    kind_t      kind1;
    state_t     state;
    logic       stopped;
  } step_t;

  function automatic class_t class_of(char_t c);
    class_t k;
    case (c) inside
      [8'h41:8'h5A], [8'h61:8'h7A]: k = ClsLetter;
      [8'h30:8'h39]:                k = ClsDigit;
      8'h7B:                        k = ClsLBrace;
      8'h7D:                        k = ClsRBrace;
      8'h28:                        k = ClsLParen;
      8'h2A:                        k = ClsStar;
      8'h29:                        k = ClsRParen;
      8'h3A:                        k = ClsColon;
      8'h3D:                        k = ClsEqual;
      8'h3C:                        k = ClsLess;
      8'h3E:                        k = ClsGreat;
      8'h20, [8'h09:8'h0D]:         k = ClsSpace;
      8'h24:                        k = ClsDollar;
      default:                      k = ClsOther;
    endcase
    return k;
  endfunction

  function automatic state_t start_row(class_t k);
    state_t n;
    unique case (k)
      ClsLetter: n = 5'd1;
      ClsDigit:  n = 5'd3;
      ClsLBrace: n = 5'd5;
      ClsLParen: n = 5'd7;
      ClsColon:  n = 5'd11;
      ClsLess:   n = 5'd13;
      ClsGreat:  n = 5'd16;
      ClsSpace:  n = StStart;
      ClsDollar: n = StStop;
      default:   n = 5'd18;
    endcase
    return n;
  endfunction

  // Transition table; out-of-range states behave as the start state
  function automatic state_t next_id(state_t s, class_t k);
    state_t n;
    unique case (s)
      5'd1:  n = (k == ClsLetter || k == ClsDigit) ? 5'd1 : StIdent;
      5'd3:  n = (k == ClsDigit) ? 5'd3 : StNumber;
      5'd5:  n = (k == ClsRBrace) ? 5'd6 : 5'd5;
      5'd7:  n = (k == ClsStar) ? 5'd8 : StPrefix;
      5'd8:  n = (k == ClsStar) ? 5'd9 : 5'd8;
      5'd9:  n = (k == ClsStar) ? 5'd9 : ((k == ClsRParen) ? 5'd10 : 5'd8);
      5'd11: n = (k == ClsEqual) ? 5'd12 : StPrefix;
      5'd13: n = (k == ClsEqual) ? 5'd14 : ((k == ClsGreat) ? 5'd15 : StPrefix);
      5'd16: n = (k == ClsEqual) ? 5'd17 : StPrefix;
      5'd2, 5'd4, 5'd6, 5'd10, 5'd12, 5'd14, 5'd15, 5'd17, 5'd18, 5'd19:
             n = StStart;
      default: n = start_row(k);
    endcase
    return n;
  endfunction

  function automatic kind_t kind_of(state_t s);
    kind_t k;
    unique case (s)
      5'd2:    k = KindIdent;
      5'd4:    k = KindNumber;
      5'd6:    k = KindBrace;
      5'd10:   k = KindParen;
      5'd12:   k = KindAssign;
      5'd14:   k = KindLe;
      5'd15:   k = KindNe;
      5'd17:   k = KindGe;
      5'd18:   k = KindError;
      5'd19:   k = KindPrefix;
      5'd20:   k = KindStop;
      default: k = KindNone;
    endcase
    return k;
  endfunction

  function automatic logic reexamine(state_t s);
    return (s == StIdent) || (s == StNumber) || (s == StPrefix);
  endfunction

endpackage

>>> rtl/tll_step.sv
`timescale 1ns / 1ps

module tll_step (
  input  tll_pkg::char_t  character,
  input  logic            line_start,
  input  tll_pkg::state_t state_cur,
  input  logic            stopped_cur,
  output tll_pkg::step_t  step
);
  import tll_pkg::*;

  class_t cls;
  state_t s0;
  state_t nid1;
  state_t nid2;
  kind_t  k1;
  kind_t  k2;
  logic   stp;

  // Restart at a line start, then walk up to two table transitions
  always_comb begin
    s0   = line_start ? StStart : state_cur;
    stp  = line_start ? 1'b0 : stopped_cur;
    cls  = class_of(character);
    nid1 = next_id(s0, cls);
    k1   = kind_of(nid1);
    nid2 = next_id(StStart, cls);
    k2   = kind_of(nid2);

    step.cnt     = 2'd0;
    step.kind0   = k1;
    step.kind1   = k2;
    step.state   = s0;
    step.stopped = stp;

    if (!stp) begin
      if (k1 == KindNone) begin
        step.state = nid1;
      end else begin
        step.cnt   = 2'd1;
        step.state = StStart;
        if (nid1 == StStop) begin
          step.stopped = 1'b1;
        end else if (reexamine(nid1)) begin
          // Look at the same character again from the start state
          if (k2 == KindNone) begin
            step.state = nid2;
          end else begin
            step.cnt = 2'd2;
            if (nid2 == StStop) begin
              step.stopped = 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

>>> rtl/table_driven_token_lexer_core.sv
`timescale 1ns / 1ps

// Table-driven lexer: one character beat per clock goes in, each character
// makes zero, one or two token beats out, with tlast on the final token of
// that character. The character is classed and run through the transition
// table in the same cycle it is taken; tokens land in a 4-entry queue that
// feeds the output port. The input takes a beat every cycle as long as the
// queue has two free slots, so the sustained rate is one character per
// cycle while tokens average at most one per character, and otherwise set
// by the single-token-per-cycle output port.

module table_driven_token_lexer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic       in_tuser,   // [0] line_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] token_kind, [7:4] zero
  output logic       out_tlast
);
  import tll_pkg::*;

  typedef struct packed {
    kind_t kind;
    logic  last;
  } entry_t;

  state_t          state_r;
  logic            stopped_r;
  step_t           step;
  entry_t          fifo_r [FifoDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [1:0]      push_cnt;
  logic            in_acc;
  logic            pop;
  entry_t          head;

  tll_step u_step (
    .character   (in_tdata),
    .line_start  (in_tuser),
    .state_cur   (state_r),
    .stopped_cur (stopped_r),
    .step        (step)
  );

  assign in_tready = (count_r <= CntW'(FifoDepth - 2));
  assign in_acc    = in_tvalid & in_tready;
  assign push_cnt  = in_acc ? step.cnt : 2'd0;
  assign pop       = out_tvalid & out_tready;

  // Advance lexer state on each accepted character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= StStart;
      stopped_r <= 1'b0;
    end else if (in_acc) begin
      state_r   <= step.state;
      stopped_r <= step.stopped;
    end
  end

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + CntW'(push_cnt) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write up to two tokens per character
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      fifo_r[wr_ptr_r] <= '{kind: step.kind0, last: (push_cnt == 2'd1)};
    end
    if (push_cnt == 2'd2) begin
      fifo_r[wr_ptr_r + PtrW'(1)] <= '{kind: step.kind1, last: 1'b1};
    end
  end

  // Drive the output beat from the queue head
  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {4'd0, head.kind};
  assign out_tlast  = head.last;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(FifoDepth))
    else $error("result queue overfilled");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_cnt == 2'd0) |=> count_r == $past(count_r) - CntW'(1))
    else $error("queue level wrong after pop");

  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && stopped_r && !in_tuser) |-> (step.cnt == 2'd0 && step.stopped))
    else $error("token produced while stopped");

  a_second_token: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && step.cnt == 2'd2) |->
      ((step.kind0 == KindIdent || step.kind0 == KindNumber ||
        step.kind0 == KindPrefix) &&
       (step.kind1 == KindError || step.kind1 == KindStop)))
    else $error("illegal token pair");

endmodule
